// ===== sv/ioct_pkg.sv =====
`default_nettype none
// Shared codes for the in-order commit tracker: event kinds, result status
// codes and configuration register indexes. No dependencies.
package ioct_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [0:0] cfg_index_t;

  localparam op_t OP_REGISTER = 2'd0;
  localparam op_t OP_CONFIRM  = 2'd1;
  localparam op_t OP_FAIL     = 2'd2;
  localparam op_t OP_CONSUME  = 2'd3;

  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_STALE      = 2'd1;
  localparam status_t ST_FULL       = 2'd2;
  localparam status_t ST_NO_ROLLBK  = 2'd3;

  localparam cfg_index_t CFG_MAX_RETRIES  = 1'd0;
  localparam cfg_index_t CFG_START_OFFSET = 1'd1;

  localparam int RETRY_BITS      = 8;
  localparam int RESET_MAX_RETRY = 3;

endpackage
`default_nettype wire

// ===== sv/in_order_commit_tracker_core.sv =====
`default_nettype none
// In-order commit tracker: ring of in-flight units, retire walk and rollback guard.
// Depends on ioct_pkg for event, status and register codes.

// One transaction on the input channel is one event; each event gives exactly one
// result transaction. Events are handled one at a time by a small sequencer around
// a ring memory of end offsets and confirmed flags, read one slot per cycle at the
// head. A register, failure report or rejected event goes from the check step
// straight to the final step, which puts its result in the output register. A
// confirm passes through the check, wait and walk steps; the retire walk reads one
// ring slot per cycle, retiring units while the head is confirmed. A consumed
// rollback passes through the skip step, where the whole window is dropped in one
// step. A finished result waits in the last step while the previous one has not
// been taken. The input channel is ready again as soon as the result is in the
// output register, so the next event can be accepted while that result waits to be taken.
module in_order_commit_tracker_core
  import ioct_pkg::*;
#(
  parameter int WINDOW      = 16,
  parameter int SEQ_BITS    = 32,
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0 up: end_offset, seq_in, zero fill.
  input  wire logic [((OFFSET_BITS + SEQ_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // Fields from bit 0 up: operation.
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0 up: seq_out, rewind_offset, dropped_bytes, committed_offset,
  // zero fill.
  output logic [((SEQ_BITS + 3 * OFFSET_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // Fields from bit 0 up: status.
  output logic [1:0]                  out_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [OFFSET_BITS-1:0] cfg_data
);

  localparam int IN_RAW  = OFFSET_BITS + SEQ_BITS;
  localparam int OUT_RAW = SEQ_BITS + 3 * OFFSET_BITS;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int CMP_W   = SEQ_BITS + 11;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SKIP  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [OFFSET_BITS-1:0] end_r, end_nxt;
  logic [SEQ_BITS-1:0]    seq_r, seq_nxt;
  status_t                status_r, status_nxt;
  logic [SEQ_BITS-1:0]    seq_out_r, seq_out_nxt;
  logic [OFFSET_BITS-1:0] rewind_r, rewind_nxt;
  logic [OFFSET_BITS-1:0] dropped_r, dropped_nxt;

  logic [RETRY_BITS-1:0]  max_retries_r, max_retries_nxt;
  logic [OFFSET_BITS-1:0] committed_r, committed_nxt;
  logic [OFFSET_BITS-1:0] last_rb_r, last_rb_nxt;
  logic [RETRY_BITS-1:0]  stuck_r, stuck_nxt;
  logic                   rb_pend_r, rb_pend_nxt;
  logic [SEQ_BITS-1:0]    head_seq_r, head_seq_nxt;
  logic [SEQ_BITS-1:0]    tail_seq_r, tail_seq_nxt;
  logic [PTR_W-1:0]       head_pos_r, head_pos_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  status_t                out_user_r, out_user_nxt;

  logic [OFFSET_BITS-1:0] end_mem [WINDOW];
  logic                   conf_mem [WINDOW];
  logic [OFFSET_BITS-1:0] end_rd_r;
  logic                   conf_rd_r;

  logic                   wr_en, wr_conf;
  logic [PTR_W-1:0]       wr_slot;

  logic [SEQ_BITS-1:0]    cnt, seq_gap;
  logic [CMP_W-1:0]       cnt_w, seq_gap_w;
  logic [PTR_W:0]         ring_step, ring_sum, ring_wrap;
  logic                   cnt_full, seq_stale, skip_hit, skip_take;
  logic [RETRY_BITS-1:0]  stuck_base;
  logic [OFFSET_BITS-1:0] commit_skip;
  logic                   in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign cnt       = tail_seq_r - head_seq_r;
  assign seq_gap   = seq_r - head_seq_r;
  assign cnt_w     = CMP_W'(cnt);
  assign seq_gap_w = CMP_W'(seq_gap);
  assign cnt_full  = (cnt_w >= CMP_W'(WINDOW));
  assign seq_stale = (seq_gap_w >= cnt_w);

  always_comb begin
    if (state_r == S_CHECK && op_r == OP_CONFIRM) begin
      ring_step = seq_gap_w[PTR_W:0];
    end else begin
      ring_step = cnt_w[PTR_W:0];
    end
    ring_sum = {1'b0, head_pos_r} + ring_step;
    if (ring_sum >= (PTR_W+1)'(WINDOW)) begin
      ring_wrap = ring_sum - (PTR_W+1)'(WINDOW);
    end else begin
      ring_wrap = ring_sum;
    end
  end

  assign stuck_base  = (committed_r != last_rb_r) ? '0 : stuck_r;
  assign skip_hit    = (max_retries_r != '0) && (stuck_r > max_retries_r);
  assign skip_take   = skip_hit && (cnt != '0) && (end_rd_r > committed_r);
  assign commit_skip = skip_take ? end_rd_r : committed_r;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    end_nxt         = end_r;
    seq_nxt         = seq_r;
    status_nxt      = status_r;
    seq_out_nxt     = seq_out_r;
    rewind_nxt      = rewind_r;
    dropped_nxt     = dropped_r;
    max_retries_nxt = max_retries_r;
    committed_nxt   = committed_r;
    last_rb_nxt     = last_rb_r;
    stuck_nxt       = stuck_r;
    rb_pend_nxt     = rb_pend_r;
    head_seq_nxt    = head_seq_r;
    tail_seq_nxt    = tail_seq_r;
    head_pos_nxt    = head_pos_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;
    wr_en           = 1'b0;
    wr_conf         = 1'b0;
    wr_slot         = ring_wrap[PTR_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_tuser;
          end_nxt     = in_tdata[OFFSET_BITS-1:0];
          seq_nxt     = in_tdata[IN_RAW-1:OFFSET_BITS];
          status_nxt  = ST_DONE;
          seq_out_nxt = '0;
          rewind_nxt  = '0;
          dropped_nxt = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_REGISTER: begin
            if (cnt_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_conf      = 1'b0;
              seq_out_nxt  = tail_seq_r;
              tail_seq_nxt = tail_seq_r + 1'b1;
            end
          end
          OP_CONFIRM: begin
            if (seq_stale) begin
              status_nxt = ST_STALE;
            end else begin
              wr_en     = 1'b1;
              wr_conf   = 1'b1;
              state_nxt = S_WAIT;
            end
          end
          OP_FAIL: begin
            if (seq_stale) begin
              status_nxt = ST_STALE;
            end else begin
              rb_pend_nxt = 1'b1;
            end
          end
          default: begin
            if (!rb_pend_r) begin
              status_nxt = ST_NO_ROLLBK;
            end else begin
              last_rb_nxt = committed_r;
              stuck_nxt   = (stuck_base == '1) ? stuck_base : stuck_base + 1'b1;
              state_nxt   = S_SKIP;
            end
          end
        endcase
      end
      S_WAIT: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (cnt != '0 && conf_rd_r) begin
          committed_nxt = end_rd_r;
          head_seq_nxt  = head_seq_r + 1'b1;
          head_pos_nxt  = (head_pos_r == PTR_W'(WINDOW - 1)) ? '0 : head_pos_r + 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SKIP: begin
        rewind_nxt    = commit_skip;
        committed_nxt = commit_skip;
        if (skip_take) begin
          dropped_nxt = end_rd_r - committed_r;
        end
        if (skip_hit) begin
          stuck_nxt   = '0;
          last_rb_nxt = commit_skip;
        end
        head_seq_nxt = tail_seq_r;
        head_pos_nxt = ring_wrap[PTR_W-1:0];
        rb_pend_nxt  = 1'b0;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = OUT_W'({committed_r, dropped_r, rewind_r, seq_out_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RETRIES: begin
          max_retries_nxt = cfg_data[RETRY_BITS-1:0];
        end
        CFG_START_OFFSET: begin
          committed_nxt = cfg_data;
          last_rb_nxt   = cfg_data;
        end
        default: begin
          max_retries_nxt = max_retries_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      max_retries_r <= RETRY_BITS'(RESET_MAX_RETRY);
      committed_r   <= '0;
      last_rb_r     <= '0;
      stuck_r       <= '0;
      rb_pend_r     <= 1'b0;
      head_seq_r    <= '0;
      tail_seq_r    <= '0;
      head_pos_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      max_retries_r <= max_retries_nxt;
      committed_r   <= committed_nxt;
      last_rb_r     <= last_rb_nxt;
      stuck_r       <= stuck_nxt;
      rb_pend_r     <= rb_pend_nxt;
      head_seq_r    <= head_seq_nxt;
      tail_seq_r    <= tail_seq_nxt;
      head_pos_r    <= head_pos_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    end_r      <= end_nxt;
    seq_r      <= seq_nxt;
    status_r   <= status_nxt;
    seq_out_r  <= seq_out_nxt;
    rewind_r   <= rewind_nxt;
    dropped_r  <= dropped_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      conf_mem[wr_slot] <= wr_conf;
      if (!wr_conf) begin
        end_mem[wr_slot] <= end_r;
      end
    end
    end_rd_r  <= end_mem[head_pos_nxt];
    conf_rd_r <= conf_mem[head_pos_nxt];
  end

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= CMP_W'(WINDOW))
    else $error("pending units exceed the ring size");

  a_consume_empties: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SKIP |=> head_seq_r == tail_seq_r)
    else $error("consumed rollback left units pending");

  a_rollback_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(rb_pend_r) |-> $past(state_r) == S_SKIP)
    else $error("rollback request cleared outside a consume");

  a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK && cnt == '0 |=> state_r == S_FIN)
    else $error("retire walk ran past the tail");

endmodule
`default_nettype wire
